[hw/rtl/sfr_pkg.sv]
// Shared types and constants for the sync framed receiver.
// No dependencies; imported by the output stage and the top level.
package sfr_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned IdxW  = 6;

  // One result item as it sits in the output register.
  typedef struct packed {
    logic             status;
    logic [ByteW-1:0] frame_byte;
    logic [IdxW-1:0]  byte_index;
    logic             last;
  } out_item_t;

endpackage

[hw/rtl/sync_framed_receiver_dedup.sv]
// Sync framed receiver with duplicate suppression: top level.
// Depends on sfr_pkg, sfr_ram and sfr_out.
//
// Each received byte is taken, then checked in the next cycle against the
// stored copy, whose byte at the same position comes out of the saved-frame
// memory read port. After the last byte of a frame, a frame equal to the
// stored copy gives one duplicate item; any other frame is replayed from the
// frame memory byte by byte (memory read, then output load and write into
// the saved copy), FRAME_LEN items in all, during which no input is taken.
// The output register lets the next byte be taken while a result still
// waits. Both memories are written before they are read and need no clearing
// after reset.
module sync_framed_receiver_dedup import sfr_pkg::*; #(
  parameter int unsigned FRAME_LEN = 29
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // [7:0] rx_byte
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [15:0]      m_tdata,   // [7:0] frame_byte, [13:8] byte_index, [15:14] zero
  output logic             m_tuser,   // [0] status
  output logic             m_tlast,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [ByteW-1:0] cfg_data
);

  localparam int unsigned AW = $clog2(FRAME_LEN);

  typedef enum logic [4:0] {
    S_IN  = 5'b00001,
    S_CHK = 5'b00010,
    S_DUP = 5'b00100,
    S_RD  = 5'b01000,
    S_WR  = 5'b10000
  } state_t;

  localparam logic CFG_SYNC_FIRST  = 1'b0;
  localparam logic CFG_SYNC_SECOND = 1'b1;

  state_t           state;
  logic [ByteW-1:0] sync_first;
  logic [ByteW-1:0] sync_second;
  logic             collecting;
  logic [AW-1:0]    fill_count;
  logic [AW-1:0]    idx;
  logic [ByteW-1:0] in_byte;
  logic [ByteW-1:0] byte0;
  logic [ByteW-1:0] byte1;
  logic             diff;
  logic             saved_valid;

  logic [ByteW-1:0] frame_rdata;
  logic [ByteW-1:0] saved_rdata;
  logic             frame_we;
  logic [AW-1:0]    frame_waddr;
  logic             saved_we;

  logic [AW:0]      cnt_next;
  logic [ByteW-1:0] second_byte;
  logic             bad_sync;
  logic             complete;
  logic             byte_diff;
  logic             differs;
  logic             out_free;
  logic             out_load;
  out_item_t        out_item;
  out_item_t        out_q;

  assign s_tready    = (state == S_IN);
  assign cnt_next    = {1'b0, fill_count} + 1'b1;
  assign second_byte = (fill_count == AW'(1)) ? in_byte : byte1;
  assign bad_sync    = (byte0 != sync_first) || (second_byte != sync_second);
  assign complete    = (cnt_next == (AW+1)'(FRAME_LEN));
  assign byte_diff   = (saved_rdata != in_byte);
  assign differs     = !saved_valid || diff || byte_diff;

  assign frame_we    = (state == S_CHK) && (collecting || (in_byte == sync_first));
  assign frame_waddr = collecting ? fill_count : '0;
  assign saved_we    = (state == S_WR) && out_free;

  sfr_ram #(.WIDTH(ByteW), .DEPTH(FRAME_LEN)) u_frame_ram (
    .clk   (clk),
    .we    (frame_we),
    .waddr (frame_waddr),
    .wdata (in_byte),
    .raddr (idx),
    .rdata (frame_rdata)
  );

  // Read the stored copy at the position of the next incoming byte.
  sfr_ram #(.WIDTH(ByteW), .DEPTH(FRAME_LEN)) u_saved_ram (
    .clk   (clk),
    .we    (saved_we),
    .waddr (idx),
    .wdata (frame_rdata),
    .raddr (fill_count),
    .rdata (saved_rdata)
  );

  always_comb begin
    out_load = 1'b0;
    out_item = '{status: 1'b1, frame_byte: '0, byte_index: '0, last: 1'b1};
    if (state == S_WR) begin
      out_load = out_free;
      out_item = '{status: 1'b0, frame_byte: frame_rdata, byte_index: IdxW'(idx),
                   last: (idx == AW'(FRAME_LEN - 1))};
    end else if (state == S_DUP) begin
      out_load = out_free;
    end else if (state == S_CHK) begin
      out_load = collecting && !bad_sync && complete && !differs && out_free;
    end
  end

  sfr_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (out_load),
    .item     (out_item),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .item_q   (out_q),
    .free     (out_free)
  );

  assign m_tdata = {2'b00, out_q.byte_index, out_q.frame_byte};
  assign m_tuser = out_q.status;
  assign m_tlast = out_q.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= 8'hAA;
      sync_second <= 8'h55;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SYNC_FIRST:  sync_first  <= cfg_data;
        CFG_SYNC_SECOND: sync_second <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IN;
      collecting  <= 1'b0;
      fill_count  <= '0;
      idx         <= '0;
      diff        <= 1'b0;
      saved_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IN: begin
          if (s_tvalid) begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          state <= S_IN;
          if (!collecting) begin
            if (in_byte == sync_first) begin
              collecting <= 1'b1;
              fill_count <= AW'(1);
              diff       <= byte_diff;
            end
          end else if (bad_sync) begin
            // drop the frame; this byte is not retried as a first sync byte
            collecting <= 1'b0;
            fill_count <= '0;
          end else if (complete) begin
            collecting <= 1'b0;
            fill_count <= '0;
            if (differs) begin
              idx   <= '0;
              state <= S_RD;
            end else if (!out_free) begin
              state <= S_DUP;
            end
          end else begin
            fill_count <= cnt_next[AW-1:0];
            diff       <= diff || byte_diff;
          end
        end
        S_DUP: begin
          if (out_free) begin
            state <= S_IN;
          end
        end
        S_RD: begin
          state <= S_WR;
        end
        S_WR: begin
          if (out_free) begin
            if (idx == AW'(FRAME_LEN - 1)) begin
              saved_valid <= 1'b1;
              state       <= S_IN;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_RD;
            end
          end
        end
        default: state <= S_IN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IN && s_tvalid) begin
      in_byte <= s_tdata;
    end
    if (state == S_CHK) begin
      if (!collecting) begin
        byte0 <= in_byte;
      end else if (fill_count == AW'(1)) begin
        byte1 <= in_byte;
      end
    end
  end

`ifndef ASSERT_OFF
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill_count < AW'(FRAME_LEN - 1) || fill_count == AW'(FRAME_LEN - 1))
    else $error("fill count beyond frame length");

  a_dup_shape: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && m_tdata == 16'h0000)
    else $error("duplicate item carries frame data");

  a_saved_after_replay: assert property (@(posedge clk) disable iff (rst)
    $rose(saved_valid) |-> $past(state == S_WR))
    else $error("stored copy marked valid outside replay");

  a_no_input_in_replay: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD || state == S_WR) |=> !(collecting && fill_count != '0))
    else $error("collection state changed during replay");
`endif

endmodule

[hw/rtl/sfr_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module sfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 29
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/sfr_out.sv]
// Output register stage of the receiver: holds one result item until taken.
// Depends on sfr_pkg.
module sfr_out import sfr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  out_item_t item,
  input  logic      m_tready,
  output logic      m_tvalid,
  output out_item_t item_q,
  output logic      free
);

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (free) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      item_q <= item;
    end
  end

endmodule
